/* hdl/integer_alu_div_pow_fact_macros.svh */
// Assertion macros for the multicycle integer ALU.
`ifndef INTEGER_ALU_DIV_POW_FACT_MACROS_SVH
`define INTEGER_ALU_DIV_POW_FACT_MACROS_SVH
`ifndef SYNTH
// Checked only out of reset.
`define IADPF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define IADPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IADPF_ASSERT(lbl, clk, rst_n, prop, msg)
`define IADPF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hdl/iadpf_pkg.sv */
// Types, codes and widths shared by the multicycle integer ALU.
package iadpf_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int KIND_W     = 3;
    // factorial counter: the product is zero by i = 2*DATA_WIDTH at the latest
    localparam int CNT_W      = $clog2(2 * DATA_WIDTH + 2);

    localparam logic [KIND_W-1:0] KIND_ADD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIV  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POW  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FACT = 3'd5;

    typedef logic [1:0] t_uop;
    localparam t_uop UOP_ADD = 2'd0;
    localparam t_uop UOP_SUB = 2'd1;
    localparam t_uop UOP_MUL = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]            kind;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic signed [DATA_WIDTH-1:0] remainder;
        logic                         error;
    } t_out_beat;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] res;
        logic                  borrow;
    } t_unit_res;

endpackage

/* hdl/integer_alu_div_pow_fact.sv */
// Add/sub/mul pass once through the shared unit; divide takes one quotient
// bit a cycle through the shared subtractor; power multiplies and squares per exponent bit;
// factorial multiplies in one factor per cycle until the product is zero or complete.
// One item at a time: in_ready is high only while the sequencer is idle. A finished
// result waits in the output register, so the next item may enter meanwhile.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
`include "integer_alu_div_pow_fact_macros.svh"

module integer_alu_div_pow_fact (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  iadpf_pkg::t_in_beat  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output iadpf_pkg::t_out_beat o_out_data
);
    localparam int W     = iadpf_pkg::DATA_WIDTH;
    localparam int CNT_W = iadpf_pkg::CNT_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ADD     = 4'd1;
    localparam logic [3:0] ST_SUB     = 4'd2;
    localparam logic [3:0] ST_MUL     = 4'd3;
    localparam logic [3:0] ST_POW_MUL = 4'd4;
    localparam logic [3:0] ST_POW_SQR = 4'd5;
    localparam logic [3:0] ST_FACT    = 4'd6;
    localparam logic [3:0] ST_ABS_A   = 4'd7;
    localparam logic [3:0] ST_ABS_B   = 4'd8;
    localparam logic [3:0] ST_DIV     = 4'd9;
    localparam logic [3:0] ST_NEG_Q   = 4'd10;
    localparam logic [3:0] ST_NEG_R   = 4'd11;
    localparam logic [3:0] ST_DONE    = 4'd12;

    localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE     = {{(W-1){1'b0}}, 1'b1};

    logic [3:0]       r_state, n_state;
    logic [W-1:0]     r_x, n_x;
    logic [W-1:0]     r_y, n_y;
    logic [W-1:0]     r_acc, n_acc;
    logic [W-1:0]     r_rem, n_rem;
    logic             r_err, n_err;
    logic             r_neg_a, n_neg_a;
    logic             r_neg_q, n_neg_q;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    iadpf_pkg::t_out_beat r_out, n_out;

    iadpf_pkg::t_uop       uop;
    logic [W-1:0]          ux;
    logic [W-1:0]          uy;
    iadpf_pkg::t_unit_res  ures;
    logic                  in_acc;
    logic                  out_free;
    logic [W-1:0]          shifted;
    logic [W-1:0]          cnt_ext;

    iadpf_unit u_unit (
        .i_op  (uop),
        .i_x   (ux),
        .i_y   (uy),
        .o_res (ures)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    // next partial remainder before the trial subtract
    assign shifted     = {r_rem[W-2:0], r_x[W-1]};
    assign cnt_ext     = {{(W-CNT_W){1'b0}}, r_cnt};

    // operand selection for the shared unit
    always_comb begin
        uop = iadpf_pkg::UOP_ADD;
        ux  = r_x;
        uy  = r_y;
        case (r_state)
            ST_SUB: begin
                uop = iadpf_pkg::UOP_SUB;
            end
            ST_MUL: begin
                uop = iadpf_pkg::UOP_MUL;
            end
            ST_POW_MUL: begin
                // odd bit: acc * base; even bit: base * base
                uop = iadpf_pkg::UOP_MUL;
                uy  = r_x;
                if (r_y[0]) begin
                    ux = r_acc;
                end
            end
            ST_POW_SQR: begin
                uop = iadpf_pkg::UOP_MUL;
                uy  = r_x;
            end
            ST_FACT: begin
                uop = iadpf_pkg::UOP_MUL;
                ux  = r_acc;
                uy  = cnt_ext;
            end
            ST_ABS_A: begin
                uop = iadpf_pkg::UOP_SUB;
                ux  = '0;
                uy  = r_x;
            end
            ST_ABS_B: begin
                uop = iadpf_pkg::UOP_SUB;
                ux  = '0;
            end
            ST_DIV: begin
                uop = iadpf_pkg::UOP_SUB;
                ux  = shifted;
            end
            ST_NEG_Q: begin
                uop = iadpf_pkg::UOP_SUB;
                ux  = '0;
                uy  = r_x;
            end
            ST_NEG_R: begin
                uop = iadpf_pkg::UOP_SUB;
                ux  = '0;
                uy  = r_rem;
            end
            default: begin
                uop = iadpf_pkg::UOP_ADD;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_err       = r_err;
        n_neg_a     = r_neg_a;
        n_neg_q     = r_neg_q;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_x   = i_in_data.operand_a;
                    n_y   = i_in_data.operand_b;
                    n_acc = ONE;
                    n_rem = '0;
                    n_err = 1'b0;
                    n_cnt = {{(CNT_W-1){1'b0}}, 1'b1};
                    case (i_in_data.kind)
                        iadpf_pkg::KIND_ADD: begin
                            n_state = ST_ADD;
                        end
                        iadpf_pkg::KIND_SUB: begin
                            n_state = ST_SUB;
                        end
                        iadpf_pkg::KIND_MUL: begin
                            n_state = ST_MUL;
                        end
                        iadpf_pkg::KIND_DIV: begin
                            if (i_in_data.operand_b == '0 ||
                                (i_in_data.operand_a == MIN_VAL &&
                                 i_in_data.operand_b == {W{1'b1}})) begin
                                n_err   = 1'b1;
                                n_acc   = '0;
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_ABS_A;
                            end
                        end
                        iadpf_pkg::KIND_POW: begin
                            // negative exponent gives 1
                            n_state = i_in_data.operand_b[W-1] ? ST_DONE : ST_POW_MUL;
                        end
                        iadpf_pkg::KIND_FACT: begin
                            n_state = i_in_data.operand_a[W-1] ? ST_DONE : ST_FACT;
                        end
                        default: begin
                            n_err   = 1'b1;
                            n_acc   = '0;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ADD, ST_SUB, ST_MUL: begin
                n_acc   = ures.res;
                n_state = ST_DONE;
            end
            ST_POW_MUL: begin
                if (r_y == '0) begin
                    n_state = ST_DONE;
                end else if (r_y[0]) begin
                    n_acc   = ures.res;
                    n_state = ST_POW_SQR;
                end else begin
                    // even bit: square straight away
                    n_x = ures.res;
                    n_y = {1'b0, r_y[W-1:1]};
                end
            end
            ST_POW_SQR: begin
                n_x     = ures.res;
                n_y     = {1'b0, r_y[W-1:1]};
                n_state = ST_POW_MUL;
            end
            ST_FACT: begin
                if (cnt_ext > r_x || r_acc == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_acc = ures.res;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ABS_A: begin
                n_neg_a = r_x[W-1];
                n_neg_q = r_x[W-1] ^ r_y[W-1];
                if (r_x[W-1]) begin
                    n_x = ures.res;
                end
                n_state = ST_ABS_B;
            end
            ST_ABS_B: begin
                if (r_y[W-1]) begin
                    n_y = ures.res;
                end
                n_rem   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // restoring step: quotient bits shift into r_x from the bottom
                n_rem = ures.borrow ? shifted : ures.res;
                n_x   = {r_x[W-2:0], !ures.borrow};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    n_state = ST_NEG_Q;
                end
            end
            ST_NEG_Q: begin
                n_acc   = r_neg_q ? ures.res : r_x;
                n_state = ST_NEG_R;
            end
            ST_NEG_R: begin
                if (r_neg_a) begin
                    n_rem = ures.res;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out.value     = r_acc;
                    n_out.remainder = r_rem;
                    n_out.error     = r_err;
                    n_out_valid     = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_x     <= n_x;
        r_y     <= n_y;
        r_acc   <= n_acc;
        r_rem   <= n_rem;
        r_err   <= n_err;
        r_neg_a <= n_neg_a;
        r_neg_q <= n_neg_q;
        r_cnt   <= n_cnt;
        r_out   <= n_out;
    end

    `IADPF_ASSERT(a_err_zero, i_clk, i_rst_n, o_out_valid && o_out_data.error |-> o_out_data.value == '0 && o_out_data.remainder == '0, "error beat carries non-zero data")
    `IADPF_ASSERT(a_busy_after_accept, i_clk, i_rst_n, in_acc |=> r_state != ST_IDLE, "sequencer idle right after accepting a beat")
    `IADPF_ASSERT(a_div_rem_bound, i_clk, i_rst_n, r_state == ST_DIV |-> r_rem < r_y, "partial remainder not below divisor")
    `IADPF_ASSERT(a_done_loads_out, i_clk, i_rst_n, r_state == ST_DONE && out_free |=> o_out_valid && r_state == ST_IDLE, "finished result not moved to output")

endmodule

/* hdl/iadpf_unit.sv */
// Shared arithmetic unit: wrapped add, subtract with borrow, low-half multiply.
module iadpf_unit (
    input  iadpf_pkg::t_uop                   i_op,
    input  logic [iadpf_pkg::DATA_WIDTH-1:0] i_x,
    input  logic [iadpf_pkg::DATA_WIDTH-1:0] i_y,
    output iadpf_pkg::t_unit_res              o_res
);
    localparam int W = iadpf_pkg::DATA_WIDTH;

    logic [W:0]   sum;
    logic [W:0]   diff;
    logic [W-1:0] prod;

    assign sum  = {1'b0, i_x} + {1'b0, i_y};
    assign diff = {1'b0, i_x} - {1'b0, i_y};
    assign prod = i_x * i_y;

    always_comb begin
        o_res.borrow = diff[W];
        case (i_op)
            iadpf_pkg::UOP_ADD: begin
                o_res.res = sum[W-1:0];
            end
            iadpf_pkg::UOP_SUB: begin
                o_res.res = diff[W-1:0];
            end
            iadpf_pkg::UOP_MUL: begin
                o_res.res = prod;
            end
            default: begin
                o_res.res = sum[W-1:0];
            end
        endcase
    end

endmodule
